// File: hdl/spq_pkg.sv
package spq_pkg;

   localparam int CLASS_DEPTH = 256;
   localparam int DESC_W      = 16;
   localparam int PTR_W       = $clog2(CLASS_DEPTH);
   localparam int CNT_W       = $clog2(CLASS_DEPTH + 1);
   localparam int ADDR_W      = PTR_W + 1;
   localparam int REG_W       = 9;
   localparam int ID_W        = 16;
   localparam int CSR_IDX_W   = 2;
   localparam int CMP_W       = ((REG_W > CNT_W) ? REG_W : CNT_W) + 1;

   localparam logic [REG_W-1:0] QUEUE_LIMIT_RESET    = REG_W'(256);
   localparam logic [REG_W-1:0] MARK_THRESHOLD_RESET = REG_W'(64);

   localparam logic [CSR_IDX_W-1:0] REG_QUEUE_LIMIT    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_MARK_THRESHOLD = CSR_IDX_W'(1);

   typedef enum logic [1:0] {
      ST_ENQUEUED = 2'd0,
      ST_DROPPED  = 2'd1,
      ST_DEQUEUED = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

   typedef enum logic {
      FUNC_ENQUEUE = 1'b0,
      FUNC_DEQUEUE = 1'b1
   } func_type;

   typedef struct packed {
      logic [DESC_W-1:0] desc;
      logic              mark;
   } entry_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      entry_type         wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_req_type;

endpackage

// File: hdl/spq_store.sv
module spq_store (
   input  logic                 clock,
   input  spq_pkg::mem_req_type mem_req,
   output spq_pkg::entry_type   rd_data
);
   import spq_pkg::*;

   entry_type mem [0:(1 << ADDR_W)-1];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/strict_priority_ecn_queue.sv
// A result word is registered in the s1 stage and then in the output stage.
// Throughput: one enqueue or dequeue per cycle unless rsp_ready stalls it,
// limited by the one write and one read port of the shared descriptor memory.
// Reset is synchronous and active high; counts, pointers and the pipeline are
// cleared at once, and the descriptor memory needs no clearing pass.
module strict_priority_ecn_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [15:0] req_packet_id,
   input  logic        req_traffic_class,
   input  logic        req_ecn_capable,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_packet_out,
   output logic        rsp_congestion_marked,
   output logic        rsp_class_out,
   output logic [8:0]  rsp_occupancy,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_data
);
   import spq_pkg::*;

   logic [REG_W-1:0] queue_limit_ff, queue_limit_in;
   logic [REG_W-1:0] mark_threshold_ff, mark_threshold_in;

   logic [PTR_W-1:0] head_ff [2];
   logic [PTR_W-1:0] head_in [2];
   logic [PTR_W-1:0] tail_ff [2];
   logic [PTR_W-1:0] tail_in [2];
   logic [CNT_W-1:0] count_ff [2];
   logic [CNT_W-1:0] count_in [2];
   logic [CNT_W-1:0] total_ff, total_in;

   logic             s1_valid_ff, s1_valid_in;
   status_type       s1_status_ff, s1_status_in;
   logic [ID_W-1:0]  s1_pkt_ff, s1_pkt_in;
   logic             s1_mark_ff, s1_mark_in;
   logic             s1_class_ff, s1_class_in;
   logic [REG_W-1:0] s1_occ_ff, s1_occ_in;

   logic             out_valid_ff, out_valid_in;
   status_type       out_status_ff;
   logic [ID_W-1:0]  out_pkt_ff, out_pkt_in;
   logic             out_mark_ff, out_mark_in;
   logic             out_class_ff;
   logic [REG_W-1:0] out_occ_ff;

   logic             accept;
   logic             s1_advance;
   mem_req_type      mem_req;
   entry_type        rd_data;

   logic [CMP_W-1:0] new_total;
   logic [CMP_W-1:0] limit;
   logic             drop;
   logic             enq_mark;
   logic             deq_class;

   spq_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   assign s1_advance = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign accept     = req_valid && req_ready;
   assign csr_ready  = 1'b1;

   always_comb begin
      queue_limit_in    = queue_limit_ff;
      mark_threshold_in = mark_threshold_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_QUEUE_LIMIT:    queue_limit_in    = csr_data;
            REG_MARK_THRESHOLD: mark_threshold_in = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      new_total = CMP_W'(total_ff) + CMP_W'(1);
      limit     = (CMP_W'(queue_limit_ff) > CMP_W'(CLASS_DEPTH)) ? CMP_W'(CLASS_DEPTH)
                                                                 : CMP_W'(queue_limit_ff);
      drop      = (new_total > limit) ||
                  (CMP_W'(count_ff[req_traffic_class]) >= CMP_W'(CLASS_DEPTH));
      enq_mark  = req_ecn_capable && (new_total > CMP_W'(mark_threshold_ff));
      deq_class = (count_ff[0] == '0);

      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      total_in = total_ff;

      mem_req.wr_en        = 1'b0;
      mem_req.wr_addr      = {req_traffic_class, tail_ff[req_traffic_class]};
      mem_req.wr_data.desc = DESC_W'(req_packet_id);
      mem_req.wr_data.mark = enq_mark;
      mem_req.rd_en        = 1'b0;
      mem_req.rd_addr      = {deq_class, head_ff[deq_class]};

      s1_status_in = ST_EMPTY;
      s1_pkt_in    = '0;
      s1_mark_in   = 1'b0;
      s1_class_in  = 1'b0;
      s1_occ_in    = '0;

      if (func_type'(req_func) == FUNC_ENQUEUE) begin
         s1_pkt_in   = ID_W'(DESC_W'(req_packet_id));
         s1_class_in = req_traffic_class;
         if (drop) begin
            s1_status_in = ST_DROPPED;
            s1_occ_in    = REG_W'(total_ff);
         end else begin
            s1_status_in  = ST_ENQUEUED;
            s1_mark_in    = enq_mark;
            s1_occ_in     = REG_W'(new_total);
            mem_req.wr_en = accept;
            if (accept) begin
               tail_in[req_traffic_class]  =
                  (tail_ff[req_traffic_class] == PTR_W'(CLASS_DEPTH - 1)) ? '0
                  : tail_ff[req_traffic_class] + PTR_W'(1);
               count_in[req_traffic_class] = count_ff[req_traffic_class] + CNT_W'(1);
               total_in = CNT_W'(new_total);
            end
         end
      end else if ((count_ff[0] != '0) || (count_ff[1] != '0)) begin
         s1_status_in  = ST_DEQUEUED;
         s1_class_in   = deq_class;
         s1_occ_in     = (total_ff != '0) ? REG_W'(total_ff - CNT_W'(1)) : '0;
         mem_req.rd_en = accept;
         if (accept) begin
            head_in[deq_class]  = (head_ff[deq_class] == PTR_W'(CLASS_DEPTH - 1)) ? '0
                                  : head_ff[deq_class] + PTR_W'(1);
            count_in[deq_class] = count_ff[deq_class] - CNT_W'(1);
            if (total_ff != '0) begin
               total_in = total_ff - CNT_W'(1);
            end
         end
      end

      s1_valid_in  = accept || (s1_valid_ff && !s1_advance);
      out_valid_in = s1_advance || (out_valid_ff && !rsp_ready);

      if (s1_status_ff == ST_DEQUEUED) begin
         out_pkt_in  = ID_W'(rd_data.desc);
         out_mark_in = rd_data.mark;
      end else begin
         out_pkt_in  = s1_pkt_ff;
         out_mark_in = s1_mark_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         queue_limit_ff    <= QUEUE_LIMIT_RESET;
         mark_threshold_ff <= MARK_THRESHOLD_RESET;
         head_ff           <= '{default: '0};
         tail_ff           <= '{default: '0};
         count_ff          <= '{default: '0};
         total_ff          <= '0;
         s1_valid_ff       <= 1'b0;
         out_valid_ff      <= 1'b0;
      end else begin
         queue_limit_ff    <= queue_limit_in;
         mark_threshold_ff <= mark_threshold_in;
         head_ff           <= head_in;
         tail_ff           <= tail_in;
         count_ff          <= count_in;
         total_ff          <= total_in;
         s1_valid_ff       <= s1_valid_in;
         out_valid_ff      <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_status_ff <= s1_status_in;
         s1_pkt_ff    <= s1_pkt_in;
         s1_mark_ff   <= s1_mark_in;
         s1_class_ff  <= s1_class_in;
         s1_occ_ff    <= s1_occ_in;
      end
      if (s1_advance) begin
         out_status_ff <= s1_status_ff;
         out_pkt_ff    <= out_pkt_in;
         out_mark_ff   <= out_mark_in;
         out_class_ff  <= s1_class_ff;
         out_occ_ff    <= s1_occ_ff;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_status            = out_status_ff;
   assign rsp_packet_out        = out_pkt_ff;
   assign rsp_congestion_marked = out_mark_ff;
   assign rsp_class_out         = out_class_ff;
   assign rsp_occupancy         = out_occ_ff;

endmodule

// File: hdl/spq_checker.sv
module spq_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [15:0] rsp_packet_out,
   input logic        rsp_congestion_marked,
   input logic        rsp_class_out,
   input logic [8:0]  rsp_occupancy
);
   import spq_pkg::*;

   // A stalled result word keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_packet_out) && $stable(rsp_occupancy))
      else $error("stalled result word changed");

   // An empty dequeue reports a cleared word.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |->
      rsp_occupancy == '0 && rsp_packet_out == '0 && !rsp_congestion_marked &&
      !rsp_class_out)
      else $error("empty dequeue with nonzero fields");

   // A dropped packet never carries a congestion mark.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_DROPPED |-> !rsp_congestion_marked)
      else $error("dropped packet marked");

   // An accepted enqueue leaves at least that packet in the queue.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_ENQUEUED |-> rsp_occupancy != '0)
      else $error("enqueue reported zero occupancy");

endmodule

bind strict_priority_ecn_queue spq_checker u_spq_checker (
   .clock                 (clock),
   .reset                 (reset),
   .rsp_valid             (rsp_valid),
   .rsp_ready             (rsp_ready),
   .rsp_status            (rsp_status),
   .rsp_packet_out        (rsp_packet_out),
   .rsp_congestion_marked (rsp_congestion_marked),
   .rsp_class_out         (rsp_class_out),
   .rsp_occupancy         (rsp_occupancy)
);
